FILE: design/npp_pkg.sv
// Shared constants, codes, transaction types and helpers for the nibble pixel plotter.
package npp_pkg;

   localparam int FRAME_BYTES   = 32768;
   localparam int CURSOR_WIDTH  = 8;
   localparam int CURSOR_HEIGHT = 14;
   localparam int LINE_BYTES    = 160;

   localparam int FRAME_AW  = $clog2(FRAME_BYTES);
   localparam int SUM_W     = 17;
   localparam int CUR_COL_W = $clog2(CURSOR_WIDTH);
   localparam int CUR_ROW_W = (CURSOR_HEIGHT > 1) ? $clog2(CURSOR_HEIGHT) : 1;
   localparam int BG_IDX_W  = CUR_ROW_W + CUR_COL_W;
   localparam int BG_DEPTH  = CURSOR_WIDTH * CURSOR_HEIGHT;

   localparam int CSR_AW     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DW     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LEFT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_TOP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_RIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_BOTTOM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_ENABLE = 3'd4;

   localparam logic [8:0] CLIP_LEFT_RESET   = 9'd0;
   localparam logic [7:0] CLIP_TOP_RESET    = 8'd0;
   localparam logic [8:0] CLIP_RIGHT_RESET  = 9'd319;
   localparam logic [7:0] CLIP_BOTTOM_RESET = 8'd199;
   localparam logic [8:0] CURSOR_COL_RESET  = 9'd160;
   localparam logic [7:0] CURSOR_ROW_RESET  = 8'd100;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CURSOR = 2'd2;
   localparam logic [1:0] CMD_ICON   = 2'd3;

   localparam logic [1:0] ICON_CLEAR = 2'd0;
   localparam logic [1:0] ICON_GRAY  = 2'd1;
   localparam logic [1:0] ICON_WHITE = 2'd2;
   localparam logic [1:0] ICON_BLACK = 2'd3;

   localparam logic [3:0] COLOR_GRAY  = 4'd7;
   localparam logic [3:0] COLOR_WHITE = 4'd15;
   localparam logic [3:0] COLOR_BLACK = 4'd0;

   typedef struct packed {
      logic [1:0]  command;
      logic [8:0]  x;
      logic [7:0]  y;
      logic [3:0]  color;
      logic [3:0]  icon_row_index;
      logic [15:0] icon_row_bits;
   } npp_req_type;

   typedef struct packed {
      logic [3:0] read_color;
      logic       pixel_written;
   } npp_rsp_type;

   typedef struct packed {
      logic [8:0] clip_left;
      logic [7:0] clip_top;
      logic [8:0] clip_right;
      logic [7:0] clip_bottom;
      logic       cursor_enable;
   } npp_cfg_type;

   typedef struct packed {
      logic look;
      logic commit;
      logic save_bg;
   } npp_cursor_ctl_type;

   typedef struct packed {
      logic       in_box;
      logic [1:0] code;
      logic [3:0] bg_color;
   } npp_cursor_stat_type;

   typedef struct packed {
      logic look;
      logic write;
   } npp_frame_ctl_type;

   function automatic logic [3:0] npp_icon_color(input logic [1:0] code,
                                                 input logic [3:0] color);
      logic [3:0] result;
      unique case (code)
         ICON_GRAY:  result = COLOR_GRAY;
         ICON_WHITE: result = COLOR_WHITE;
         ICON_BLACK: result = COLOR_BLACK;
         default:    result = color;
      endcase
      return result;
   endfunction

endpackage

FILE: design/npp_csr.sv
// Configuration register bank behind the APB-style port.
module npp_csr
   import npp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready,
   output npp_cfg_type         cfg
);

   npp_cfg_type          cfg_ff;
   npp_cfg_type          cfg_in;
   logic                 wr_en;
   logic [CSR_IDX_W-1:0] index;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = paddr[CSR_AW-1:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_CLIP_LEFT:     cfg_in.clip_left     = pwdata[8:0];
            CSR_CLIP_TOP:      cfg_in.clip_top      = pwdata[7:0];
            CSR_CLIP_RIGHT:    cfg_in.clip_right    = pwdata[8:0];
            CSR_CLIP_BOTTOM:   cfg_in.clip_bottom   = pwdata[7:0];
            CSR_CURSOR_ENABLE: cfg_in.cursor_enable = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left     <= CLIP_LEFT_RESET;
         cfg_ff.clip_top      <= CLIP_TOP_RESET;
         cfg_ff.clip_right    <= CLIP_RIGHT_RESET;
         cfg_ff.clip_bottom   <= CLIP_BOTTOM_RESET;
         cfg_ff.cursor_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         CSR_CLIP_LEFT:     prdata = CSR_DW'(cfg_ff.clip_left);
         CSR_CLIP_TOP:      prdata = CSR_DW'(cfg_ff.clip_top);
         CSR_CLIP_RIGHT:    prdata = CSR_DW'(cfg_ff.clip_right);
         CSR_CLIP_BOTTOM:   prdata = CSR_DW'(cfg_ff.clip_bottom);
         CSR_CURSOR_ENABLE: prdata = CSR_DW'(cfg_ff.cursor_enable);
         default:           prdata = '0;
      endcase
   end

endmodule

FILE: design/npp_cursor.sv
// Cursor position, icon rows and background store with per-entry valid bits.
module npp_cursor
   import npp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  npp_req_type         item,
   input  npp_cursor_ctl_type  ctl,
   output npp_cursor_stat_type stat
);

   logic [8:0]            col_ff;
   logic [7:0]            row_ff;
   logic [15:0]           icon_ff [CURSOR_HEIGHT];
   logic [BG_DEPTH-1:0]   bg_valid_ff;
   logic [3:0]            bg_mem [BG_DEPTH];

   logic                  in_box_ff;
   logic [BG_IDX_W-1:0]   idx_ff;
   logic [1:0]            code_ff;
   logic [3:0]            bg_rd_ff;
   logic                  bg_vld_rd_ff;

   logic [9:0]            dx;
   logic [8:0]            dy;
   logic                  in_box_in;
   logic [CUR_COL_W-1:0]  cx;
   logic [CUR_ROW_W-1:0]  cy;
   logic [BG_IDX_W-1:0]   idx_in;
   logic [15:0]           icon_row;
   logic [CUR_COL_W-1:0]  shift_pos;
   logic [1:0]            code_in;
   logic                  icon_load;

   assign dx = {1'b0, item.x} - {1'b0, col_ff};
   assign dy = {1'b0, item.y} - {1'b0, row_ff};
   assign in_box_in = (item.x >= col_ff) && (dx < 10'(CURSOR_WIDTH)) &&
                      (item.y >= row_ff) && (dy < 9'(CURSOR_HEIGHT));
   assign cx        = dx[CUR_COL_W-1:0];
   assign cy        = dy[CUR_ROW_W-1:0];
   assign idx_in    = {cy, cx};
   assign icon_row  = in_box_in ? icon_ff[cy] : '0;
   assign shift_pos = CUR_COL_W'(CURSOR_WIDTH - 1) - cx;
   assign code_in   = icon_row[{shift_pos, 1'b0} +: 2];
   assign icon_load = ctl.commit && (item.command == CMD_ICON) &&
                      ({1'b0, item.icon_row_index} < 5'(CURSOR_HEIGHT));

   always_ff @(posedge clock) begin
      if (ctl.look) begin
         in_box_ff    <= in_box_in;
         idx_ff       <= idx_in;
         code_ff      <= code_in;
         bg_rd_ff     <= bg_mem[idx_in];
         bg_vld_rd_ff <= bg_valid_ff[idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.save_bg) begin
         bg_mem[idx_ff] <= item.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= CURSOR_COL_RESET;
         row_ff      <= CURSOR_ROW_RESET;
         bg_valid_ff <= '0;
         for (int i = 0; i < CURSOR_HEIGHT; i++) begin
            icon_ff[i] <= '0;
         end
      end else begin
         if (ctl.commit && (item.command == CMD_CURSOR)) begin
            col_ff <= item.x;
            row_ff <= item.y;
         end
         if (icon_load) begin
            icon_ff[item.icon_row_index[CUR_ROW_W-1:0]] <= item.icon_row_bits;
         end
         if (ctl.save_bg) begin
            bg_valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   assign stat.in_box   = in_box_ff;
   assign stat.code     = code_ff;
   assign stat.bg_color = bg_vld_rd_ff ? bg_rd_ff : 4'd0;

endmodule

FILE: design/npp_frame.sv
// Framebuffer memory with address generation and nibble read-modify-write.
module npp_frame
   import npp_pkg::*;
(
   input  logic              clock,
   input  npp_req_type       item,
   input  npp_frame_ctl_type ctl,
   input  logic [3:0]        wr_color,
   output logic [3:0]        rd_nibble
);

   logic [7:0]          frame_mem [FRAME_BYTES];
   logic [FRAME_AW-1:0] addr_ff;
   logic [7:0]          rd_ff;

   logic [SUM_W-1:0]    sum;
   logic [SUM_W-1:0]    wrapped;
   logic [FRAME_AW-1:0] addr_in;
   logic [7:0]          wr_byte;

   assign sum     = SUM_W'(item.y) * SUM_W'(LINE_BYTES) + SUM_W'(item.x[8:1]);
   assign wrapped = (sum >= SUM_W'(FRAME_BYTES)) ? sum - SUM_W'(FRAME_BYTES) : sum;
   assign addr_in = wrapped[FRAME_AW-1:0];

   assign wr_byte   = item.x[0] ? {rd_ff[7:4], wr_color} : {wr_color, rd_ff[3:0]};
   assign rd_nibble = item.x[0] ? rd_ff[3:0] : rd_ff[7:4];

   always_ff @(posedge clock) begin
      if (ctl.look) begin
         addr_ff <= addr_in;
         rd_ff   <= frame_mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         frame_mem[addr_ff] <= wr_byte;
      end
   end

endmodule

FILE: design/nibble_pixel_plotter_with_cursor_unit.sv
// Result strobe registered from the done state, after the look state; one per command.
// A new command is taken in the done state, while the previous one completes; pacing is
// set by the framebuffer read then write-back of the same byte through its single port.
// Reset: sequencer idle, registers to defaults, cursor at column 160 row 100, icon rows
// and background valid bits cleared; framebuffer contents undefined, no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module nibble_pixel_plotter_with_cursor_unit
   import npp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  npp_req_type       req_data,
   output logic              rsp_valid,
   output npp_rsp_type       rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   npp_req_type         item_ff;
   logic                rsp_valid_ff;
   npp_rsp_type         rsp_data_ff;
   npp_rsp_type         rsp_data_in;

   npp_cfg_type         cfg;
   npp_cursor_ctl_type  cur_ctl;
   npp_cursor_stat_type cur_stat;
   npp_frame_ctl_type   frm_ctl;
   logic [3:0]          frm_nibble;

   logic                accept;
   logic                in_look;
   logic                in_done;
   logic                is_write;
   logic                is_read;
   logic                clip_ok;
   logic                draw_icon;
   logic [3:0]          draw_color;

   assign busy    = (state_ff == ST_LOOK);
   assign accept  = start & ~busy;
   assign in_look = (state_ff == ST_LOOK);
   assign in_done = (state_ff == ST_DONE);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_LOOK : ST_IDLE;
         ST_LOOK: state_in = ST_DONE;
         ST_DONE: state_in = accept ? ST_LOOK : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= in_done;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign is_write = (item_ff.command == CMD_WRITE);
   assign is_read  = (item_ff.command == CMD_READ);
   assign clip_ok  = (item_ff.x >= cfg.clip_left) && (item_ff.y >= cfg.clip_top) &&
                     (item_ff.x <= cfg.clip_right) && (item_ff.y <= cfg.clip_bottom);
   assign draw_icon  = cfg.cursor_enable & cur_stat.in_box;
   assign draw_color = draw_icon ? npp_icon_color(cur_stat.code, item_ff.color)
                                 : item_ff.color;

   assign cur_ctl.look    = in_look;
   assign cur_ctl.commit  = in_done;
   assign cur_ctl.save_bg = in_done & is_write & draw_icon;

   assign frm_ctl.look  = in_look;
   assign frm_ctl.write = in_done & is_write & clip_ok;

   always_comb begin
      rsp_data_in.read_color    = 4'd0;
      rsp_data_in.pixel_written = is_write & clip_ok;
      if (is_read) begin
         rsp_data_in.read_color = cur_stat.in_box ? cur_stat.bg_color : frm_nibble;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   npp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   npp_cursor u_cursor (
      .clock (clock),
      .reset (reset),
      .item  (item_ff),
      .ctl   (cur_ctl),
      .stat  (cur_stat)
   );

   npp_frame u_frame (
      .clock     (clock),
      .item      (item_ff),
      .ctl       (frm_ctl),
      .wr_color  (draw_color),
      .rd_nibble (frm_nibble)
   );

endmodule

FILE: test/nibble_pixel_plotter_with_cursor_unit_tb.sv
// Self-checking testbench for the nibble pixel plotter: directed and random commands.
module nibble_pixel_plotter_with_cursor_unit_tb
   import npp_pkg::*;
();

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_X         = 511;
   localparam int MAX_Y         = 255;

   typedef struct packed {
      logic [8:0] x;
      logic [7:0] y;
   } pixel_spot_type;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   logic              busy;
   npp_req_type       req_data = '0;
   logic              rsp_valid;
   npp_rsp_type       rsp_data;
   logic              psel     = 1'b0;
   logic              penable  = 1'b0;
   logic              pwrite   = 1'b0;
   logic [CSR_AW-1:0] paddr    = '0;
   logic [CSR_DW-1:0] pwdata   = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   nibble_pixel_plotter_with_cursor_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted block state
   bit [7:0]  frame_bytes [FRAME_BYTES];
   bit [3:0]  saved_under [BG_DEPTH];
   bit [15:0] icon_rows   [CURSOR_HEIGHT];
   int        box_col   = int'(CURSOR_COL_RESET);
   int        box_row   = int'(CURSOR_ROW_RESET);
   bit [8:0]  clip_l    = CLIP_LEFT_RESET;
   bit [7:0]  clip_t    = CLIP_TOP_RESET;
   bit [8:0]  clip_r    = CLIP_RIGHT_RESET;
   bit [7:0]  clip_b    = CLIP_BOTTOM_RESET;
   bit        cursor_on = 1'b0;

   // stimulus-side view: cursor position and nibbles already stored
   int             plan_col = int'(CURSOR_COL_RESET);
   int             plan_row = int'(CURSOR_ROW_RESET);
   bit             nibble_stored [2*FRAME_BYTES];
   pixel_spot_type stored_spots [$];

   npp_req_type pending_commands [$];
   npp_rsp_type expected_results [$];
   int          commands_queued = 0;
   int          results_seen    = 0;
   int          failures        = 0;
   int          cycle_count     = 0;

   function automatic bit in_box(int col, int row, int x, int y);
      return x >= col && x < col + CURSOR_WIDTH && y >= row && y < row + CURSOR_HEIGHT;
   endfunction

   function automatic bit clip_pass(int x, int y);
      return x >= int'(clip_l) && x <= int'(clip_r) && y >= int'(clip_t) && y <= int'(clip_b);
   endfunction

   function automatic int byte_of(int x, int y);
      return (y * LINE_BYTES + x / 2) % FRAME_BYTES;
   endfunction

   function automatic npp_rsp_type plot_command(npp_req_type cmd);
      npp_rsp_type rsp;
      int          x, y, cx, cy, a;
      bit [3:0]    shade;
      bit [1:0]    code;
      rsp = '0;
      x = int'(cmd.x);
      y = int'(cmd.y);
      cx = x - box_col;
      cy = y - box_row;
      case (cmd.command)
         CMD_WRITE: begin
            shade = cmd.color;
            if (cursor_on && in_box(box_col, box_row, x, y)) begin
               code = 2'(icon_rows[cy] >> (2 * (CURSOR_WIDTH - 1 - cx)));
               saved_under[cy * CURSOR_WIDTH + cx] = cmd.color;
               case (code)
                  ICON_GRAY:  shade = COLOR_GRAY;
                  ICON_WHITE: shade = COLOR_WHITE;
                  ICON_BLACK: shade = COLOR_BLACK;
                  default:    shade = cmd.color;
               endcase
            end
            if (clip_pass(x, y)) begin
               a = byte_of(x, y);
               if (x % 2) frame_bytes[a][3:0] = shade;
               else frame_bytes[a][7:4] = shade;
               rsp.pixel_written = 1'b1;
            end
         end
         CMD_READ: begin
            if (in_box(box_col, box_row, x, y)) begin
               rsp.read_color = saved_under[cy * CURSOR_WIDTH + cx];
            end else begin
               a = byte_of(x, y);
               rsp.read_color = (x % 2) ? frame_bytes[a][3:0] : frame_bytes[a][7:4];
            end
         end
         CMD_CURSOR: begin
            box_col = x;
            box_row = y;
         end
         default: begin
            if (int'(cmd.icon_row_index) < CURSOR_HEIGHT)
               icon_rows[cmd.icon_row_index] = cmd.icon_row_bits;
         end
      endcase
      return rsp;
   endfunction

   task automatic note_failure(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
   endtask

   function automatic bit readable(int x, int y);
      return in_box(plan_col, plan_row, x, y) || nibble_stored[byte_of(x, y) * 2 + x % 2];
   endfunction

   function automatic void queue_command(logic [1:0] op, int x, int y, int color, int row,
                                         int bits);
      npp_req_type    cmd;
      pixel_spot_type s;
      cmd.command        = op;
      cmd.x              = 9'(x);
      cmd.y              = 8'(y);
      cmd.color          = 4'(color);
      cmd.icon_row_index = 4'(row);
      cmd.icon_row_bits  = 16'(bits);
      if (op == CMD_WRITE && clip_pass(x, y)) begin
         nibble_stored[byte_of(x, y) * 2 + x % 2] = 1'b1;
         s.x = 9'(x);
         s.y = 8'(y);
         stored_spots.push_back(s);
      end
      if (op == CMD_CURSOR) begin
         plan_col = x;
         plan_row = y;
      end
      pending_commands.push_back(cmd);
      commands_queued++;
   endfunction

   task automatic queue_random_phase(int count);
      int             pick, x, y;
      pixel_spot_type s;
      repeat (count) begin
         pick = $urandom_range(99);
         x = $urandom_range(MAX_X);
         y = $urandom_range(MAX_Y);
         if (pick < 45) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               x = plan_col + int'($urandom_range(11)) - 2;
               y = plan_row + int'($urandom_range(17)) - 2;
            end else if (pick < 55 && stored_spots.size() != 0) begin
               s = stored_spots[$];
               x = int'(s.x) ^ int'($urandom_range(1));
               y = int'(s.y);
            end else if (pick < 65) begin
               x = int'($urandom_range(1) ? clip_l : clip_r) + int'($urandom_range(2)) - 1;
               y = int'($urandom_range(1) ? clip_t : clip_b) + int'($urandom_range(2)) - 1;
            end
         end else if (pick < 80) begin
            pick = $urandom_range(99);
            if (pick < 40 && stored_spots.size() != 0) begin
               s = stored_spots[$];
               x = int'(s.x);
               y = int'(s.y);
            end else if (pick < 65 && stored_spots.size() != 0) begin
               s = stored_spots[$urandom_range(stored_spots.size() - 1)];
               x = int'(s.x);
               y = int'(s.y);
            end else if (pick < 90 || !readable(x, y)) begin
               x = plan_col + int'($urandom_range(CURSOR_WIDTH - 1));
               y = plan_row + int'($urandom_range(CURSOR_HEIGHT - 1));
            end
         end else if (pick < 88 && $urandom_range(1) && stored_spots.size() != 0) begin
            s = stored_spots[$];
            x = int'(s.x) - int'($urandom_range(CURSOR_WIDTH - 1));
            y = int'(s.y) - int'($urandom_range(CURSOR_HEIGHT - 1));
         end
         x = (x < 0) ? 0 : (x > MAX_X) ? MAX_X : x;
         y = (y < 0) ? 0 : (y > MAX_Y) ? MAX_Y : y;
         queue_command((pick < 45) ? CMD_WRITE : (pick < 80) ? CMD_READ :
                       (pick < 88) ? CMD_CURSOR : CMD_ICON,
                       x, y, $urandom_range(15), $urandom_range(15), $urandom_range(65535));
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_CLIP_LEFT:   clip_l = 9'(value);
         CSR_CLIP_TOP:    clip_t = 8'(value);
         CSR_CLIP_RIGHT:  clip_r = 9'(value);
         CSR_CLIP_BOTTOM: clip_b = 8'(value);
         default:         cursor_on = 1'(value);
      endcase
   endtask

   task automatic csr_check(logic [CSR_IDX_W-1:0] idx, int want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         note_failure($sformatf("register %0d expected %0d got %0d", idx, want, prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(int left, int top, int right, int bottom, int enable);
      csr_write(CSR_CLIP_LEFT, left);
      csr_write(CSR_CLIP_TOP, top);
      csr_write(CSR_CLIP_RIGHT, right);
      csr_write(CSR_CLIP_BOTTOM, bottom);
      csr_write(CSR_CURSOR_ENABLE, enable);
      csr_check(CSR_CLIP_LEFT, left);
      csr_check(CSR_CLIP_TOP, top);
      csr_check(CSR_CLIP_RIGHT, right);
      csr_check(CSR_CLIP_BOTTOM, bottom);
      csr_check(CSR_CURSOR_ENABLE, enable);
   endtask

   task automatic wait_idle();
      while (results_seen < commands_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin : drive_commands
      logic        launch;
      npp_req_type next_cmd;
      launch   = start;
      next_cmd = req_data;
      if (reset) begin
         launch = 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(plot_command(req_data));
            launch = 1'b0;
         end
         if (!launch && pending_commands.size() != 0 &&
             (cycle_count[11:10] == 2'b11 || $urandom_range(99) >= 23)) begin
            next_cmd = pending_commands.pop_front();
            launch   = 1'b1;
         end
      end
      start    <= launch;
      req_data <= next_cmd;
   end

   always @(posedge clock) begin : check_results
      npp_rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected transaction %p", rsp_data));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.read_color !== want.read_color)
               note_failure($sformatf("read_color expected %0d got %0d",
                                      want.read_color, rsp_data.read_color));
            if (rsp_data.pixel_written !== want.pixel_written)
               note_failure($sformatf("pixel_written expected %0d got %0d",
                                      want.pixel_written, rsp_data.pixel_written));
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int left, top, right, bottom, enable;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      csr_check(CSR_CLIP_LEFT, int'(CLIP_LEFT_RESET));
      csr_check(CSR_CLIP_TOP, int'(CLIP_TOP_RESET));
      csr_check(CSR_CLIP_RIGHT, int'(CLIP_RIGHT_RESET));
      csr_check(CSR_CLIP_BOTTOM, int'(CLIP_BOTTOM_RESET));
      csr_check(CSR_CURSOR_ENABLE, 0);

      // reset clip window, cursor disabled at its home position
      queue_command(CMD_READ, 160, 100, 0, 0, 0);
      queue_command(CMD_WRITE, 0, 0, 15, 0, 0);
      queue_command(CMD_WRITE, 1, 0, 0, 15, 16'hFFFF);
      queue_command(CMD_READ, 0, 0, 0, 0, 0);
      queue_command(CMD_WRITE, 319, 199, 9, 0, 0);
      queue_command(CMD_READ, 319, 199, 0, 0, 0);
      queue_command(CMD_WRITE, 320, 199, 3, 0, 0);
      queue_command(CMD_WRITE, 511, 255, 15, 0, 0);
      queue_command(CMD_ICON, 0, 0, 0, 0, 16'h6C6C);
      queue_command(CMD_ICON, 0, 0, 0, CURSOR_HEIGHT - 1, 16'hFFFF);
      queue_command(CMD_ICON, 0, 0, 0, 14, 16'h5555);
      queue_command(CMD_ICON, 0, 0, 0, 15, 16'hAAAA);
      queue_command(CMD_WRITE, 160, 100, 4, 0, 0);
      queue_command(CMD_READ, 160, 100, 0, 0, 0);
      queue_command(CMD_CURSOR, 0, 0, 0, 0, 0);
      queue_command(CMD_READ, 0, 0, 0, 0, 0);
      wait_idle();

      // cursor composited, left edge of the box clipped off
      configure(2, 0, MAX_X, MAX_Y, 1);
      queue_command(CMD_WRITE, 0, 0, 5, 0, 0);
      queue_command(CMD_WRITE, 1, 0, 5, 0, 0);
      queue_command(CMD_WRITE, 2, 0, 5, 0, 0);
      queue_command(CMD_WRITE, 3, 0, 5, 0, 0);
      queue_command(CMD_READ, 0, 0, 0, 0, 0);
      queue_command(CMD_CURSOR, 100, 50, 0, 0, 0);
      queue_command(CMD_READ, 0, 0, 0, 0, 0);
      queue_command(CMD_READ, 2, 0, 0, 0, 0);
      queue_command(CMD_READ, 3, 0, 0, 0, 0);
      queue_command(CMD_WRITE, MAX_X, MAX_Y, 6, 0, 0);
      queue_command(CMD_READ, 255, 51, 0, 0, 0);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         left   = $urandom_range(300);
         right  = left + int'($urandom_range(MAX_X - left));
         top    = $urandom_range(200);
         bottom = top + int'($urandom_range(MAX_Y - top));
         enable = $urandom_range(1);
         case (phase)
            0: configure(0, 0, MAX_X, MAX_Y, 1);
            1: configure(int'(CLIP_LEFT_RESET), int'(CLIP_TOP_RESET), int'(CLIP_RIGHT_RESET),
                         int'(CLIP_BOTTOM_RESET), 0);
            2: configure(MAX_X, MAX_Y, 0, 0, 1);
            3: configure(0, 0, 0, 0, 1);
            4: configure(MAX_X, MAX_Y, MAX_X, MAX_Y, 0);
            default: configure(left, top, right, bottom, enable);
         endcase
         queue_random_phase(200);
         wait_idle();
      end

      if (expected_results.size() != 0)
         note_failure($sformatf("%0d transactions never arrived", expected_results.size()));
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
